// ===== hdl/adsr_eg_pkg.sv =====
package adsr_eg_pkg;

   // envelope stages as shown on the result channel
   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_ATTACK  = 3'd1,
      ST_DECAY   = 3'd2,
      ST_SUSTAIN = 3'd3,
      ST_RELEASE = 3'd4
   } stage_type;

   // request operations
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_NOTE_ON  = 2'd1,
      OP_NOTE_OFF = 2'd2,
      OP_ALL_OFF  = 2'd3
   } op_type;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN_LEVEL  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_COEFF   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_COEFF    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_COEFF  = 3'd5;

   // level format, 1.0 = 65536
   localparam logic [16:0] LVL_ONE = 17'd65536;
   // detector and threshold format, 1.0 = 16384
   localparam logic [14:0] THR_MAX = 15'd16384;
   // held note counter saturation
   localparam logic [10:0] HELD_MAX = 11'd1024;

   // overshooting pole targets
   localparam logic signed [17:0] ATK_TGT = 18'sd81920;
   localparam logic signed [17:0] REL_TGT = -18'sd1966;

   // stage end bounds on the stepped level
   localparam logic signed [21:0] ATK_END = 22'sd65530;
   localparam logic signed [21:0] SEG_EPS = 22'sd6;

   // gate decision handed from the gate logic to the core
   typedef struct packed {
      logic gate;
      logic armed;
      logic retrig;
   } gate_result_type;

endpackage

// ===== hdl/adsr_eg_req_if.sv =====
interface adsr_eg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] detector;

   modport source (output valid, output operation, output detector, input ready);
   modport sink (input valid, input operation, input detector, output ready);
endinterface

// ===== hdl/adsr_eg_rsp_if.sv =====
interface adsr_eg_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] level;
   logic [2:0]  stage_now;
   logic        gate_open;

   modport source (output valid, output level, output stage_now, output gate_open,
                   input ready);
   modport sink (input valid, input level, input stage_now, input gate_open,
                 output ready);
endinterface

// ===== hdl/adsr_envelope_with_gate_core.sv =====
// exponential adsr envelope, advanced by one tick request per audio block
//
// req_ch carries requests: operation (tick, note on, note off, all notes off)
// and the detector level used by ticks. rsp_ch returns one result per tick
// (level, stage_now, gate_open); note events update the held note count and
// give no result. csr_* writes one configuration register per cycle and is
// to be used only while the block is idle.
//
// a tick's request is taken into the input register, and its result is loaded
// into the result register once that register has room.
// throughput: one request per cycle while no stalled result holds a tick,
// set by the single multiply-add of the pole step between those registers.
//
// reset clears the envelope to idle with level zero, the gate closed and
// armed, the held note count and all configuration registers to zero.
// when rsp_ch stalls the result is held; the input register still takes one
// more request, note events keep flowing, and a waiting tick holds req_ch.
module adsr_envelope_with_gate_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [adsr_eg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [adsr_eg_pkg::CSR_DATA_W-1:0]  csr_data,
   adsr_eg_req_if.sink                        req_ch,
   adsr_eg_rsp_if.source                      rsp_ch
);
   import adsr_eg_pkg::*;

   // configuration
   logic        trigger_mode_ff;
   logic [14:0] open_threshold_ff;
   logic [16:0] sustain_level_ff;
   logic [15:0] attack_coeff_ff;
   logic [15:0] decay_coeff_ff;
   logic [15:0] release_coeff_ff;

   // envelope state
   stage_type   stage_ff, stage_in;
   logic [16:0] level_ff, level_in;
   logic [10:0] held_ff, held_in;
   logic        pending_ff, pending_in;
   logic        gate_ff, gate_in;
   logic        armed_ff, armed_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   op_type      in_op_ff;
   logic [15:0] in_det_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [16:0] out_level_ff;
   stage_type   out_stage_ff;
   logic        out_gate_ff;

   logic            in_is_tick;
   logic            out_free;
   logic            in_fire;
   logic            tick_fire;
   logic            req_fire;
   logic [16:0]     sus_sat;
   gate_result_type gate_res;
   stage_type       step_stage;
   logic [16:0]     step_level;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_mode_ff   <= 1'b0;
         open_threshold_ff <= '0;
         sustain_level_ff  <= '0;
         attack_coeff_ff   <= '0;
         decay_coeff_ff    <= '0;
         release_coeff_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TRIGGER_MODE:   trigger_mode_ff   <= csr_data[0];
            CSR_OPEN_THRESHOLD: open_threshold_ff <= csr_data[14:0];
            CSR_SUSTAIN_LEVEL:  sustain_level_ff  <= csr_data[16:0];
            CSR_ATTACK_COEFF:   attack_coeff_ff   <= csr_data[15:0];
            CSR_DECAY_COEFF:    decay_coeff_ff    <= csr_data[15:0];
            CSR_RELEASE_COEFF:  release_coeff_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // handshake: a tick moves on only when the result register has room
   always_comb begin
      in_is_tick   = (in_op_ff == OP_TICK);
      out_free     = !out_valid_ff || rsp_ch.ready;
      in_fire      = in_valid_ff && (!in_is_tick || out_free);
      tick_fire    = in_fire && in_is_tick;
      req_ch.ready = !in_valid_ff || in_fire;
      req_fire     = req_ch.valid && req_ch.ready;
      in_valid_in  = req_fire ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);
      out_valid_in = tick_fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff  <= op_type'(req_ch.operation);
         in_det_ff <= req_ch.detector;
      end
   end

   // gate decision
   adsr_eg_gate u_gate (
      .trigger_mode   (trigger_mode_ff),
      .threshold      (open_threshold_ff),
      .detector       (in_det_ff),
      .gate_cur       (gate_ff),
      .armed_cur      (armed_ff),
      .held_nonzero   (held_ff != 11'd0),
      .retrig_pending (pending_ff),
      .result         (gate_res)
   );

   // pole step and stage ends
   assign sus_sat = (sustain_level_ff > LVL_ONE) ? LVL_ONE : sustain_level_ff;

   adsr_eg_step u_step (
      .stage_cur     (stage_ff),
      .gate          (gate_res.gate),
      .retrig        (gate_res.retrig),
      .level         (level_ff),
      .sustain       (sus_sat),
      .attack_coeff  (attack_coeff_ff),
      .decay_coeff   (decay_coeff_ff),
      .release_coeff (release_coeff_ff),
      .stage_nxt     (step_stage),
      .level_nxt     (step_level)
   );

   // next envelope and note state
   always_comb begin
      stage_in   = stage_ff;
      level_in   = level_ff;
      held_in    = held_ff;
      pending_in = pending_ff;
      gate_in    = gate_ff;
      armed_in   = armed_ff;
      if (in_fire) begin
         case (in_op_ff)
            OP_TICK: begin
               stage_in   = step_stage;
               level_in   = step_level;
               gate_in    = gate_res.gate;
               armed_in   = gate_res.armed;
               pending_in = 1'b0;
            end
            OP_NOTE_ON: begin
               if (held_ff < HELD_MAX) begin
                  held_in = held_ff + 11'd1;
               end
               pending_in = 1'b1;
            end
            OP_NOTE_OFF: begin
               if (held_ff != 11'd0) begin
                  held_in = held_ff - 11'd1;
               end
            end
            OP_ALL_OFF: begin
               held_in = 11'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= ST_IDLE;
         level_ff   <= '0;
         held_ff    <= '0;
         pending_ff <= 1'b0;
         gate_ff    <= 1'b0;
         armed_ff   <= 1'b1;
      end else begin
         stage_ff   <= stage_in;
         level_ff   <= level_in;
         held_ff    <= held_in;
         pending_ff <= pending_in;
         gate_ff    <= gate_in;
         armed_ff   <= armed_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         out_level_ff <= step_level;
         out_stage_ff <= step_stage;
         out_gate_ff  <= gate_res.gate;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.level     = out_level_ff;
   assign rsp_ch.stage_now = out_stage_ff;
   assign rsp_ch.gate_open = out_gate_ff;

endmodule

// ===== hdl/adsr_eg_gate.sv =====
module adsr_eg_gate (
   input  logic                         trigger_mode,
   input  logic [14:0]                  threshold,
   input  logic [15:0]                  detector,
   input  logic                         gate_cur,
   input  logic                         armed_cur,
   input  logic                         held_nonzero,
   input  logic                         retrig_pending,
   output adsr_eg_pkg::gate_result_type result
);
   import adsr_eg_pkg::*;

   logic [14:0] thr_sat;
   logic [19:0] det_x10;
   logic [19:0] thr_x7;
   logic        below;

   // hysteresis compare: detector under 0.7 of the threshold
   always_comb begin
      thr_sat = (threshold > THR_MAX) ? THR_MAX : threshold;
      det_x10 = 20'(detector) * 20'd10;
      thr_x7  = 20'(thr_sat) * 20'd7;
      below   = det_x10 < thr_x7;
   end

   // gate decision for one tick
   always_comb begin
      result.gate   = gate_cur;
      result.armed  = armed_cur;
      result.retrig = 1'b0;
      if (!trigger_mode) begin
         // transient detector with re-arming
         if (!gate_cur && armed_cur && (20'(detector) >= 20'(thr_sat))) begin
            result.gate   = 1'b1;
            result.armed  = 1'b0;
            result.retrig = 1'b1;
         end else if (gate_cur && below) begin
            result.gate = 1'b0;
         end
         if (!result.gate && below) begin
            result.armed = 1'b1;
         end
      end else begin
         // held note count, pending note-on retriggers
         result.gate = held_nonzero | retrig_pending;
         result.retrig = retrig_pending;
      end
   end

endmodule

// ===== hdl/adsr_eg_step.sv =====
module adsr_eg_step (
   input  adsr_eg_pkg::stage_type stage_cur,
   input  logic                   gate,
   input  logic                   retrig,
   input  logic [16:0]            level,
   input  logic [16:0]            sustain,
   input  logic [15:0]            attack_coeff,
   input  logic [15:0]            decay_coeff,
   input  logic [15:0]            release_coeff,
   output adsr_eg_pkg::stage_type stage_nxt,
   output logic [16:0]            level_nxt
);
   import adsr_eg_pkg::*;

   stage_type          stage_pre;
   logic               idle_or_rel;
   logic signed [17:0] target;
   logic [15:0]        coeff;
   logic signed [18:0] diff;
   logic signed [35:0] prod;
   logic signed [37:0] acc;
   logic signed [21:0] stepped;
   logic signed [21:0] sus_s;
   logic signed [21:0] raw;

   // stage change driven by the gate
   always_comb begin
      idle_or_rel = (stage_cur == ST_IDLE) || (stage_cur == ST_RELEASE);
      stage_pre   = stage_cur;
      if (retrig || (gate && idle_or_rel)) begin
         stage_pre = ST_ATTACK;
      end else if (!gate && !idle_or_rel) begin
         stage_pre = ST_RELEASE;
      end
   end

   // one-pole step toward the stage target, rounded half up
   always_comb begin
      sus_s = $signed({5'b0, sustain});
      case (stage_pre)
         ST_ATTACK: begin
            target = ATK_TGT;
            coeff  = attack_coeff;
         end
         ST_DECAY: begin
            target = $signed({1'b0, sustain});
            coeff  = decay_coeff;
         end
         ST_RELEASE: begin
            target = REL_TGT;
            coeff  = release_coeff;
         end
         default: begin
            target = $signed({1'b0, sustain});
            coeff  = 16'd0;
         end
      endcase
      diff    = $signed({2'b0, level}) - $signed({target[17], target});
      prod    = $signed({1'b0, coeff}) * diff;
      acc     = $signed({{4{target[17]}}, target, 16'b0})
              + $signed({{2{prod[35]}}, prod}) + 38'sd32768;
      stepped = acc[37:16];
   end

   // stage ends and clamp
   always_comb begin
      stage_nxt = stage_pre;
      raw       = stepped;
      case (stage_pre)
         ST_ATTACK: begin
            if (stepped >= ATK_END) begin
               raw       = $signed({5'b0, LVL_ONE});
               stage_nxt = ST_DECAY;
            end
         end
         ST_DECAY: begin
            if (stepped <= sus_s + SEG_EPS) begin
               raw       = sus_s;
               stage_nxt = ST_SUSTAIN;
            end
         end
         ST_SUSTAIN: begin
            raw = sus_s;
         end
         ST_RELEASE: begin
            if (stepped <= SEG_EPS) begin
               raw       = 22'sd0;
               stage_nxt = ST_IDLE;
            end
         end
         default: begin
            raw       = 22'sd0;
            stage_nxt = ST_IDLE;
         end
      endcase
      if (raw < 22'sd0) begin
         level_nxt = 17'd0;
      end else if (raw > $signed({5'b0, LVL_ONE})) begin
         level_nxt = LVL_ONE;
      end else begin
         level_nxt = raw[16:0];
      end
   end

endmodule

// ===== hdl/adsr_eg_checker.sv =====
module adsr_eg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [16:0] rsp_level,
   input logic [2:0]  rsp_stage_now,
   input logic        rsp_gate_open
);
   import adsr_eg_pkg::*;

   // a stalled result holds still
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level)
            && $stable(rsp_stage_now) && $stable(rsp_gate_open);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("stalled result changed");

   // no result straight after reset
   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_empty: assert property (p_reset_empty) else $error("result valid after reset");

   // level never exceeds full scale
   property p_level_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> rsp_level <= LVL_ONE;
   endproperty
   a_level_range: assert property (p_level_range) else $error("level above full scale");

   // idle means silence
   property p_idle_silent;
      @(posedge clock) disable iff (reset)
         rsp_valid && (rsp_stage_now == ST_IDLE) |-> rsp_level == 17'd0;
   endproperty
   a_idle_silent: assert property (p_idle_silent) else $error("idle with nonzero level");

   // attack, decay and sustain only with the gate open
   property p_gate_stage;
      @(posedge clock) disable iff (reset)
         rsp_valid && ((rsp_stage_now == ST_ATTACK) || (rsp_stage_now == ST_DECAY)
            || (rsp_stage_now == ST_SUSTAIN)) |-> rsp_gate_open;
   endproperty
   a_gate_stage: assert property (p_gate_stage) else $error("active stage with gate closed");

endmodule

bind adsr_envelope_with_gate_core adsr_eg_checker u_adsr_eg_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_level     (rsp_ch.level),
   .rsp_stage_now (rsp_ch.stage_now),
   .rsp_gate_open (rsp_ch.gate_open)
);
